// File: sv/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FIELD_WIDTH = 16;
  localparam int EXT_WIDTH   = 32;

  localparam logic [1:0] SEEN_FIRST  = 2'd0;
  localparam logic [1:0] SEEN_SECOND = 2'd1;
  localparam logic [1:0] SEEN_THIRD  = 2'd2;
  localparam logic [1:0] SEEN_MORE   = 2'd3;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] x_coord;
    logic signed [FIELD_WIDTH-1:0] y_coord;
    logic                          last_point;
  } vertex_t;

  typedef struct packed {
    logic convex;
    logic too_few;
  } result_t;

  typedef struct packed {
    logic [1:0] idx;
    logic       last;
  } tag_t;

endpackage

`default_nettype wire

// File: sv/pcc_cross.sv
`default_nettype none

module pcc_cross #(
  parameter int DW = pcc_pkg::COORD_WIDTH + 1
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [DW-1:0] d1x,
  input  wire logic signed [DW-1:0] d1y,
  input  wire logic signed [DW-1:0] d2x,
  input  wire logic signed [DW-1:0] d2y,
  output logic                      neg
);

  logic signed [2*DW-1:0] p_a;
  logic signed [2*DW-1:0] p_b;
  logic signed [2*DW:0]   z;

  always_ff @(posedge clk) begin
    if (en) begin
      p_a <= d1x * d2y;
      p_b <= d1y * d2x;
    end
  end

  assign z   = (2*DW+1)'(p_a) - (2*DW+1)'(p_b);
  assign neg = z[2*DW];

endmodule

`default_nettype wire

// File: sv/polygon_convexity_check_unit.sv
`default_nettype none

// Convexity test for a stream of polygon vertices, one vertex word per cycle while
// vertex_ready is high, with last_point marking the closing vertex. Its result word
// passes the edge-difference and product registers and waits in an output register
// while following vertices keep flowing. The datapath is a three-step pipeline: edge
// differences, then six registered multipliers (one pair per turn: the running
// triple and the two wrap-around triples), then the sign compare that updates the
// turn state. Only a result stalled behind a second finished polygon holds the
// input. Polygons of fewer than three vertices report convex with too_few set; a
// zero cross product counts as a non-negative turn.
module polygon_convexity_check_unit #(
  parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vertex_valid,
  output logic                  vertex_ready,
  input  wire pcc_pkg::vertex_t vertex,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output pcc_pkg::result_t      result
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;

  logic [pcc_pkg::EXT_WIDTH-1:0] x_ext;
  logic [pcc_pkg::EXT_WIDTH-1:0] y_ext;
  logic signed [CW-1:0]          x_cur;
  logic signed [CW-1:0]          y_cur;

  logic signed [CW-1:0] first_x, first_y, second_x, second_y;
  logic signed [CW-1:0] older_x, older_y, newer_x, newer_y;
  logic [1:0]           seen_count;
  logic [1:0]           seen_count_next;

  logic signed [DW-1:0] e0x, e0y, e1x, e1y, e2x, e2y, e3x, e3y;
  logic                 s1_v;
  pcc_pkg::tag_t        s1_tag;
  logic                 s2_v;
  pcc_pkg::tag_t        s2_tag;
  logic                 s1_load, s2_load, s2_go, out_free, accept;

  logic neg_main, neg_wrap1, neg_wrap2;
  logic ref_negative, mismatch;
  logic ref_eff, mism_eff, mism_all;

  assign x_ext = pcc_pkg::EXT_WIDTH'(unsigned'(vertex.x_coord));
  assign y_ext = pcc_pkg::EXT_WIDTH'(unsigned'(vertex.y_coord));
  assign x_cur = signed'(x_ext[CW-1:0]);
  assign y_cur = signed'(y_ext[CW-1:0]);

  assign out_free     = !result_valid || result_ready;
  assign s2_go        = s2_v && (!s2_tag.last || out_free);
  assign s2_load      = !s2_v || s2_go;
  assign s1_load      = !s1_v || s2_load;
  assign vertex_ready = s1_load;
  assign accept       = vertex_valid && vertex_ready;

  always_comb begin
    if (vertex.last_point) begin
      seen_count_next = pcc_pkg::SEEN_FIRST;
    end else if (seen_count == pcc_pkg::SEEN_MORE) begin
      seen_count_next = pcc_pkg::SEEN_MORE;
    end else begin
      seen_count_next = seen_count + 2'd1;
    end
  end

  // capture vertex history
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= pcc_pkg::SEEN_FIRST;
    end else if (accept) begin
      seen_count <= seen_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (seen_count == pcc_pkg::SEEN_FIRST) begin
        first_x <= x_cur;
        first_y <= y_cur;
      end
      if (seen_count == pcc_pkg::SEEN_SECOND) begin
        second_x <= x_cur;
        second_y <= y_cur;
      end
      older_x <= newer_x;
      older_y <= newer_y;
      newer_x <= x_cur;
      newer_y <= y_cur;
    end
  end

  // edge differences
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_load) begin
      s1_v <= vertex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag.idx  <= seen_count;
      s1_tag.last <= vertex.last_point;
      e0x <= DW'(newer_x) - DW'(older_x);
      e0y <= DW'(newer_y) - DW'(older_y);
      e1x <= DW'(x_cur) - DW'(newer_x);
      e1y <= DW'(y_cur) - DW'(newer_y);
      e2x <= DW'(first_x) - DW'(x_cur);
      e2y <= DW'(first_y) - DW'(y_cur);
      e3x <= DW'(second_x) - DW'(first_x);
      e3y <= DW'(second_y) - DW'(first_y);
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_load) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_v) begin
      s2_tag <= s1_tag;
    end
  end

  pcc_cross #(.DW(DW)) u_main (
    .clk (clk), .en (s2_load && s1_v),
    .d1x (e0x), .d1y (e0y), .d2x (e1x), .d2y (e1y),
    .neg (neg_main)
  );

  pcc_cross #(.DW(DW)) u_wrap1 (
    .clk (clk), .en (s2_load && s1_v),
    .d1x (e1x), .d1y (e1y), .d2x (e2x), .d2y (e2y),
    .neg (neg_wrap1)
  );

  pcc_cross #(.DW(DW)) u_wrap2 (
    .clk (clk), .en (s2_load && s1_v),
    .d1x (e2x), .d1y (e2y), .d2x (e3x), .d2y (e3y),
    .neg (neg_wrap2)
  );

  // sign compare
  always_comb begin
    if (s2_tag.idx == pcc_pkg::SEEN_THIRD) begin
      ref_eff  = neg_main;
      mism_eff = 1'b0;
    end else begin
      ref_eff  = ref_negative;
      mism_eff = mismatch || (neg_main != ref_negative);
    end
    mism_all = mism_eff || (neg_wrap1 != ref_eff) || (neg_wrap2 != ref_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_negative <= 1'b0;
      mismatch     <= 1'b0;
    end else if (s2_go) begin
      if (s2_tag.last) begin
        ref_negative <= 1'b0;
        mismatch     <= 1'b0;
      end else if (s2_tag.idx == pcc_pkg::SEEN_THIRD || s2_tag.idx == pcc_pkg::SEEN_MORE) begin
        ref_negative <= ref_eff;
        mismatch     <= mism_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_go && s2_tag.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_tag.last) begin
      if (s2_tag.idx == pcc_pkg::SEEN_FIRST || s2_tag.idx == pcc_pkg::SEEN_SECOND) begin
        result.convex  <= 1'b1;
        result.too_few <= 1'b1;
      end else begin
        result.convex  <= !mism_all;
        result.too_few <= 1'b0;
      end
    end
  end

  a_too_few_convex : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.too_few |-> result.convex)
    else $error("too_few result without convex");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !vertex_ready |-> s1_v && s2_v && s2_tag.last && result_valid && !result_ready)
    else $error("input held without a blocked result");

  a_count_restart : assert property (@(posedge clk) disable iff (rst)
    accept && vertex.last_point |=> seen_count == pcc_pkg::SEEN_FIRST)
    else $error("vertex count not restarted after last vertex");

  a_state_cleared : assert property (@(posedge clk) disable iff (rst)
    s2_go && s2_tag.last |=> !ref_negative && !mismatch)
    else $error("turn state not cleared after polygon");

endmodule

`default_nettype wire

// File: tb/tb_polygon_convexity_check_unit.sv
`default_nettype none

module tb_polygon_convexity_check_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [pcc_pkg::FIELD_WIDTH-1:0] x;
    logic signed [pcc_pkg::FIELD_WIDTH-1:0] y;
    logic                                   last;
    logic                                   typed;
    pcc_pkg::result_t                       want;
  } plan_row_t;

  typedef struct {
    pcc_pkg::vertex_t v;
    bit               typed;
    pcc_pkg::result_t want;
  } outline_word_t;

  localparam int PLAN_ROWS = 21;
  localparam int RANDOM_WORDS = 1800;
  localparam int MAX_SIDES = 40;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{16'sh7fff, 16'sh8000, 1'b1, 1'b1, '{1'b1, 1'b1}},
    '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, '{1'b1, 1'b1}},
    '{16'sd0,    16'sd0,    1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd100,  16'sd0,    1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd0,    16'sd100,  1'b1, 1'b1, '{1'b1, 1'b0}},
    '{16'sh8000, 16'sh8000, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sh8000, 16'sh7fff, 1'b1, 1'b1, '{1'b1, 1'b0}},
    '{16'sd0,    16'sd0,    1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd10,   16'sd0,    1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd2,    16'sd2,    1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd0,    16'sd10,   1'b1, 1'b0, '{1'b0, 1'b0}},
    '{16'sd0,    16'sd0,    1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd1,    16'sd1,    1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd2,    16'sd2,    1'b1, 1'b1, '{1'b1, 1'b0}},
    '{16'sd0,    16'sd0,    1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd0,    16'sd10,   1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd10,   16'sd10,   1'b0, 1'b0, '{1'b0, 1'b0}},
    '{16'sd10,   16'sd0,    1'b1, 1'b0, '{1'b0, 1'b0}}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             vertex_valid = 1'b0;
  logic             vertex_ready;
  pcc_pkg::vertex_t vertex = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  pcc_pkg::result_t result;

  outline_word_t    outline_words[$];
  pcc_pkg::result_t pending_results[$];
  int               taken = 0;
  int               errors = 0;
  int               send_calm = 0;
  int               recv_calm = 0;

  longint           first_x, first_y, second_x, second_y;
  longint           older_x, older_y, newer_x, newer_y;
  logic[1:0]        seen = pcc_pkg::SEEN_FIRST;
  bit               turn_ref_neg = 1'b0;
  bit               turn_bad = 1'b0;
  bit               closed;
  pcc_pkg::result_t verdict;

  polygon_convexity_check_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic bit turn_is_neg(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
    longint z;
    z = (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
    return z < 0;
  endfunction

  task automatic trace_vertex(input pcc_pkg::vertex_t v, output bit done,
                              output pcc_pkg::result_t r);
    longint    x;
    longint    y;
    logic[1:0] idx;
    bit        neg;
    x = longint'(v.x_coord);
    y = longint'(v.y_coord);
    idx = seen;
    r = '0;
    if (idx == pcc_pkg::SEEN_FIRST) begin
      first_x = x;
      first_y = y;
    end else if (idx == pcc_pkg::SEEN_SECOND) begin
      second_x = x;
      second_y = y;
    end else begin
      neg = turn_is_neg(older_x, older_y, newer_x, newer_y, x, y);
      if (idx == pcc_pkg::SEEN_THIRD) begin
        turn_ref_neg = neg;
        turn_bad = 1'b0;
      end else if (neg != turn_ref_neg) begin
        turn_bad = 1'b1;
      end
    end
    older_x = newer_x;
    older_y = newer_y;
    newer_x = x;
    newer_y = y;
    if (seen != pcc_pkg::SEEN_MORE) seen = seen + 2'd1;
    done = v.last_point;
    if (done) begin
      if (idx == pcc_pkg::SEEN_FIRST || idx == pcc_pkg::SEEN_SECOND) begin
        r.convex = 1'b1;
        r.too_few = 1'b1;
      end else begin
        if (turn_is_neg(older_x, older_y, x, y, first_x, first_y) != turn_ref_neg)
          turn_bad = 1'b1;
        if (turn_is_neg(x, y, first_x, first_y, second_x, second_y) != turn_ref_neg)
          turn_bad = 1'b1;
        r.convex = !turn_bad;
        r.too_few = 1'b0;
      end
      seen = pcc_pkg::SEEN_FIRST;
      turn_ref_neg = 1'b0;
      turn_bad = 1'b0;
    end
  endtask

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, 10);
  endfunction

  function automatic void add_word(int x, int y, bit last, bit typed,
                                   pcc_pkg::result_t want);
    outline_word_t w;
    w.v.x_coord = x[pcc_pkg::FIELD_WIDTH-1:0];
    w.v.y_coord = y[pcc_pkg::FIELD_WIDTH-1:0];
    w.v.last_point = last;
    w.typed = typed;
    w.want = want;
    outline_words.insert(outline_words.size(), w);
  endfunction

  always @(posedge clk) begin
    if (!rst && vertex_valid && vertex_ready) begin
      trace_vertex(outline_words[taken].v, closed, verdict);
      if (closed)
        pending_results.insert(pending_results.size(),
                               outline_words[taken].typed ?
                               outline_words[taken].want : verdict);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, got convex %b too_few %b",
                 $time, result.convex, result.too_few);
        errors++;
      end else begin
        if (result.convex !== pending_results[0].convex) begin
          $display("%0t: convex expected %b, got %b",
                   $time, pending_results[0].convex, result.convex);
          errors++;
        end
        if (result.too_few !== pending_results[0].too_few) begin
          $display("%0t: too_few expected %b, got %b",
                   $time, pending_results[0].too_few, result.too_few);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int  n;
    int  kind;
    int  rad;
    int  lim;
    int  cx;
    int  cy;
    int  dent;
    int  gap;
    int  px[MAX_SIDES];
    int  py[MAX_SIDES];
    real ang;
    real start;
    real dir;

    for (int i = 0; i < PLAN_ROWS; i++)
      add_word(PLAN[i].x, PLAN[i].y, PLAN[i].last, PLAN[i].typed, PLAN[i].want);

    while (outline_words.size() < PLAN_ROWS + RANDOM_WORDS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) :
          ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_SIDES) :
                                        $urandom_range(3, 12);
      kind = $urandom_range(0, 3);
      if (kind == 3) begin
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 1) == 0) begin
            px[k] = int'($urandom_range(0, 65535)) - 32768;
            py[k] = int'($urandom_range(0, 65535)) - 32768;
          end else begin
            px[k] = int'($urandom_range(0, 8)) - 4;
            py[k] = int'($urandom_range(0, 8)) - 4;
          end
        end
      end else begin
        rad = 1 << $urandom_range(2, 14);
        rad = rad + $urandom_range(0, rad - 1);
        lim = 32767 - rad;
        cx = int'($urandom_range(0, 2 * lim)) - lim;
        cy = int'($urandom_range(0, 2 * lim)) - lim;
        start = $urandom_range(0, 6283) / 1000.0;
        dir = ($urandom_range(0, 1) == 0) ? 1.0 : -1.0;
        for (int k = 0; k < n; k++) begin
          ang = start + dir * 6.283185307 * (k + $urandom_range(0, 400) / 1000.0) / n;
          px[k] = cx + $rtoi(rad * $cos(ang));
          py[k] = cy + $rtoi(rad * $sin(ang));
        end
        if (kind == 2) begin
          dent = $urandom_range(0, n - 1);
          lim = $urandom_range(2, 8);
          px[dent] = cx + (px[dent] - cx) / lim;
          py[dent] = cy + (py[dent] - cy) / lim;
        end
      end
      for (int k = 0; k < n; k++)
        add_word(px[k], py[k], k == n - 1, 1'b0, '0);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < outline_words.size(); i++) begin
      gap = draw_wait(send_calm);
      if (gap > 0) begin
        vertex_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      vertex_valid <= 1'b1;
      vertex <= outline_words[i].v;
      do @(posedge clk); while (!vertex_ready);
    end
    vertex_valid <= 1'b0;
    @(posedge clk);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
